// ----- src/ncp_pkg.sv -----
// ----------------------------------------------------------------------------
// ncp_pkg: shared widths and stage types of the normalized cross product unit
// Holds the derived widths and the structs that travel along the cell chains.
// ----------------------------------------------------------------------------
package ncp_pkg;

	localparam int IN_W   = 16;
	localparam int FRAC_W = 14;
	localparam int OUT_W  = FRAC_W + 2;
	localparam int PROD_W = 2 * IN_W;
	localparam int CR_W   = 2 * IN_W + 1;
	localparam int MAG_W  = 2 * IN_W;
	localparam int SUM_W  = 4 * IN_W;
	localparam int RT_W   = 2 * IN_W;
	localparam int REM_W  = RT_W + 2;
	localparam int Q_W    = FRAC_W + 1;

	// State handed from one square root cell to the next.
	typedef struct packed {
		logic                       valid;
		logic [SUM_W-1:0]           s;
		logic [RT_W-1:0]            root;
		logic [REM_W-1:0]           rem;
		logic [2:0][MAG_W-1:0]      mag;
		logic [2:0]                 neg;
		logic                       zero;
	} sq_t;

	// State handed from one divider cell to the next.
	typedef struct packed {
		logic                       valid;
		logic [RT_W-1:0]            len;
		logic [2:0][REM_W-1:0]      r;
		logic [2:0][Q_W-1:0]        q;
		logic [2:0]                 neg;
		logic                       zero;
	} dv_t;

endpackage

// ----- src/ncp_if.sv -----
// ----------------------------------------------------------------------------
// ncp_in_if / ncp_out_if: item channels of the normalized cross product unit
// Valid/ready channels carrying the vector pair and the unit vector.
// ----------------------------------------------------------------------------
interface ncp_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [ncp_pkg::IN_W-1:0]   first_x;
	logic signed [ncp_pkg::IN_W-1:0]   first_y;
	logic signed [ncp_pkg::IN_W-1:0]   first_z;
	logic signed [ncp_pkg::IN_W-1:0]   second_x;
	logic signed [ncp_pkg::IN_W-1:0]   second_y;
	logic signed [ncp_pkg::IN_W-1:0]   second_z;

	modport source (output valid, first_x, first_y, first_z, second_x, second_y,
		second_z, input ready);
	modport sink (input valid, first_x, first_y, first_z, second_x, second_y,
		second_z, output ready);
endinterface

interface ncp_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [ncp_pkg::OUT_W-1:0]  unit_x;
	logic signed [ncp_pkg::OUT_W-1:0]  unit_y;
	logic signed [ncp_pkg::OUT_W-1:0]  unit_z;
	logic                              degenerate;

	modport source (output valid, unit_x, unit_y, unit_z, degenerate, input ready);
	modport sink (input valid, unit_x, unit_y, unit_z, degenerate, output ready);
endinterface

// ----- src/ncp_front.sv -----
// ----------------------------------------------------------------------------
// ncp_front: cross product and squared length
// Four stages: products, differences with magnitudes, squares, sum of squares.
// ----------------------------------------------------------------------------
module ncp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic signed [ncp_pkg::IN_W-1:0]  ax,
	input  logic signed [ncp_pkg::IN_W-1:0]  ay,
	input  logic signed [ncp_pkg::IN_W-1:0]  az,
	input  logic signed [ncp_pkg::IN_W-1:0]  bx,
	input  logic signed [ncp_pkg::IN_W-1:0]  by,
	input  logic signed [ncp_pkg::IN_W-1:0]  bz,
	output ncp_pkg::sq_t                     sq_out
);
	import ncp_pkg::*;

	logic                          v_s1, v_s2, v_s3, v_s4;
	logic signed [PROD_W-1:0]      p_s1 [6];
	logic [2:0][MAG_W-1:0]         mag_s2, mag_s3, mag_s4;
	logic [2:0]                    neg_s2, neg_s3, neg_s4;
	logic [2:0][SUM_W-1:0]         sqr_s3;
	logic [SUM_W-1:0]              sum_s4;
	logic signed [CR_W-1:0]        cr [3];
	logic [CR_W-1:0]               ab [3];

	// Control: stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Differences of the products and their magnitudes.
	always_comb begin
		cr[0] = CR_W'(p_s1[0]) - CR_W'(p_s1[1]);
		cr[1] = CR_W'(p_s1[2]) - CR_W'(p_s1[3]);
		cr[2] = CR_W'(p_s1[4]) - CR_W'(p_s1[5]);
		for (int k = 0; k < 3; k++) begin
			ab[k] = cr[k][CR_W-1] ? (~cr[k] + 1'b1) : cr[k];
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= ay * bz;
			p_s1[1] <= az * by;
			p_s1[2] <= az * bx;
			p_s1[3] <= ax * bz;
			p_s1[4] <= ax * by;
			p_s1[5] <= ay * bx;
			for (int k = 0; k < 3; k++) begin
				mag_s2[k] <= ab[k][MAG_W-1:0];
				neg_s2[k] <= cr[k][CR_W-1];
				sqr_s3[k] <= mag_s2[k] * mag_s2[k];
			end
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			sum_s4 <= sqr_s3[0] + sqr_s3[1] + sqr_s3[2];
		end
	end

	// Seed of the square root chain.
	always_comb begin
		sq_out.valid = v_s4;
		sq_out.s     = sum_s4;
		sq_out.root  = '0;
		sq_out.rem   = '0;
		sq_out.mag   = mag_s4;
		sq_out.neg   = neg_s4;
		sq_out.zero  = (sum_s4 == '0);
	end

endmodule

// ----- src/ncp_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// ncp_sqrt_cell: one root bit of the integer square root
// Brings in two bits of the radicand and decides one bit of the root.
// ----------------------------------------------------------------------------
module ncp_sqrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  ncp_pkg::sq_t  d_in,
	output ncp_pkg::sq_t  d_out
);
	import ncp_pkg::*;

	logic [REM_W-1:0] rem_sh, trial;
	logic             ge;
	sq_t              nxt;
	logic             valid_q;
	sq_t              data_q;

	// Restoring step: compare the shifted remainder with 4*root+1.
	always_comb begin
		rem_sh    = {d_in.rem[REM_W-3:0], d_in.s[SUM_W-1:SUM_W-2]};
		trial     = {d_in.root, 2'b01};
		ge        = (rem_sh >= trial);
		nxt       = d_in;
		nxt.s     = {d_in.s[SUM_W-3:0], 2'b00};
		nxt.root  = {d_in.root[RT_W-2:0], ge};
		nxt.rem   = ge ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	// The valid bit comes from the reset register, the rest from the data register.
	always_comb begin
		d_out       = data_q;
		d_out.valid = valid_q;
	end

endmodule

// ----- src/ncp_div_cell.sv -----
// ----------------------------------------------------------------------------
// ncp_div_cell: one quotient bit for all three components
// Restoring division step of each component magnitude by the length.
// ----------------------------------------------------------------------------
module ncp_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  ncp_pkg::dv_t  d_in,
	output ncp_pkg::dv_t  d_out
);
	import ncp_pkg::*;

	logic [REM_W-1:0] den;
	logic [REM_W-1:0] rn;
	logic             ge;
	dv_t              nxt;
	logic             valid_q;
	dv_t              data_q;

	// Subtract the length where it fits, then shift the remainder up.
	always_comb begin
		den = {2'b00, d_in.len};
		nxt = d_in;
		rn  = '0;
		ge  = 1'b0;
		for (int k = 0; k < 3; k++) begin
			ge       = (d_in.r[k] >= den);
			rn       = ge ? (d_in.r[k] - den) : d_in.r[k];
			nxt.r[k] = {rn[REM_W-2:0], 1'b0};
			nxt.q[k] = {d_in.q[k][Q_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	// The valid bit comes from the reset register, the rest from the data register.
	always_comb begin
		d_out       = data_q;
		d_out.valid = valid_q;
	end

endmodule

// ----- src/normalized_cross_product_unit.sv -----
// ----------------------------------------------------------------------------
// normalized_cross_product_unit: unit normal of two 3D vectors
// Cross product, integer square root and scaled division as a chain of cells.
//
//   channel | direction | payload
//   req     | in        | first_x/y/z, second_x/y/z (signed Q8.8)
//   rsp     | out       | unit_x/y/z (signed Q1.14), degenerate
//
// One item is accepted per cycle while rsp does not stall. The path runs
// through four front stages, one square root cell per root bit, one
// divider cell per quotient bit, and the output register.
// Reset clears the valid bits only. A stall on rsp freezes the whole chain
// and drops req.ready in the same cycle.
// ----------------------------------------------------------------------------
module normalized_cross_product_unit (
	input  logic       clk,
	input  logic       arst_n,
	ncp_in_if.sink     req,
	ncp_out_if.source  rsp
);
	import ncp_pkg::*;

	logic                    en;
	logic                    valid_q;
	logic [2:0][OUT_W-1:0]   unit_q;
	logic                    degen_q;
	sq_t                     sq [RT_W+1];
	dv_t                     dv [Q_W+1];
	logic [OUT_W-1:0]        qx [3];

	// The chain moves whenever the output register is free or being taken.
	assign en        = !valid_q || rsp.ready;
	assign req.ready = en;

	ncp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (req.valid),
		.ax       (req.first_x),
		.ay       (req.first_y),
		.az       (req.first_z),
		.bx       (req.second_x),
		.by       (req.second_y),
		.bz       (req.second_z),
		.sq_out   (sq[0])
	);

	// Square root chain.
	for (genvar i = 0; i < RT_W; i++) begin : g_sqrt
		ncp_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_in   (sq[i]),
			.d_out  (sq[i+1])
		);
	end

	// Seed of the divider chain from the finished root.
	always_comb begin
		dv[0].valid = sq[RT_W].valid;
		dv[0].len   = sq[RT_W].root;
		dv[0].neg   = sq[RT_W].neg;
		dv[0].zero  = sq[RT_W].zero;
		for (int k = 0; k < 3; k++) begin
			dv[0].r[k] = {2'b00, sq[RT_W].mag[k]};
			dv[0].q[k] = '0;
		end
	end

	// Divider chain.
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		ncp_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_in   (dv[j]),
			.d_out  (dv[j+1])
		);
	end

	// Apply signs; a zero cross product gives the zero vector.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qx[k] = {1'b0, dv[Q_W].q[k]};
			if (dv[Q_W].zero) begin
				qx[k] = '0;
			end else if (dv[Q_W].neg[k]) begin
				qx[k] = ~qx[k] + 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= dv[Q_W].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_q[0] <= qx[0];
			unit_q[1] <= qx[1];
			unit_q[2] <= qx[2];
			degen_q   <= dv[Q_W].zero;
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.unit_x     = unit_q[0];
	assign rsp.unit_y     = unit_q[1];
	assign rsp.unit_z     = unit_q[2];
	assign rsp.degenerate = degen_q;

endmodule
